@@ design/vamr_pkg.sv @@
// shared constants, payload types and arithmetic helpers for the vector align rotation core
`timescale 1ns / 1ps
package vamr_pkg;

	localparam int IN_BITS   = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_W     = FRAC_BITS + 2;
	localparam int WB        = 30;
	localparam int NW        = WB + 2;
	localparam int DW        = 2 * NW;
	localparam int PW        = $clog2(NW);
	localparam int SQRT_LAT  = NW;
	localparam int DIV_LAT   = WB + 1;
	localparam int NORM_LAT  = 5 + SQRT_LAT + DIV_LAT + 1;
	localparam int S_DLY     = NORM_LAT - SQRT_LAT - 3;
	localparam int OMC_DLY   = NORM_LAT - 1;
	localparam int AB_DLY    = NORM_LAT + 3;
	localparam int Q_DLY     = 3;
	localparam int TOTAL_LAT = 2 * NORM_LAT + 9;
	localparam int R_SHIFT   = 2 * WB - FRAC_BITS;

	typedef logic [2:0][NW-1:0] vec3_t;

	typedef struct packed {
		logic signed [IN_BITS-1:0] a_x;
		logic signed [IN_BITS-1:0] a_y;
		logic signed [IN_BITS-1:0] a_z;
		logic signed [IN_BITS-1:0] b_x;
		logic signed [IN_BITS-1:0] b_y;
		logic signed [IN_BITS-1:0] b_z;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m00;
		logic signed [OUT_W-1:0] m01;
		logic signed [OUT_W-1:0] m02;
		logic signed [OUT_W-1:0] m10;
		logic signed [OUT_W-1:0] m11;
		logic signed [OUT_W-1:0] m12;
		logic signed [OUT_W-1:0] m20;
		logic signed [OUT_W-1:0] m21;
		logic signed [OUT_W-1:0] m22;
		logic                    degenerate;
	} out_t;

	// round half away from zero, then arithmetic shift right
	function automatic logic signed [DW-1:0] rnd_shr(input logic signed [DW-1:0] x,
		input int sh);
		logic signed [DW-1:0] h;
		h = 64'sd1 <<< (sh - 1);
		if (x[DW-1]) begin
			h = h - 64'sd1;
		end
		return (x + h) >>> sh;
	endfunction

	// position of the highest set bit
	function automatic logic [PW-1:0] msb_pos(input logic [NW-1:0] v);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < NW; i++) begin
			if (v[i]) begin
				p = PW'(i);
			end
		end
		return p;
	endfunction

endpackage

@@ design/vamr_delay.sv @@
// fixed-length register line for side data that rides along the datapath
`timescale 1ns / 1ps
module vamr_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] pipe_q [D];

	always_ff @(posedge clk) begin
		pipe_q[0] <= d;
		for (int i = 1; i < D; i++) begin
			pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[D-1];
endmodule

@@ design/vamr_isqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module vamr_isqrt (
	input  logic                      clk,
	input  logic [2*vamr_pkg::NW-1:0] rad,
	output logic [vamr_pkg::NW-1:0]   root
);
	import vamr_pkg::*;

	localparam int RW = 2 * NW;

	logic [RW-1:0] rem_s [SQRT_LAT];
	logic [RW-1:0] acc_s [SQRT_LAT];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
		logic [RW-1:0] rem_in;
		logic [RW-1:0] acc_in;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = rad;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign trial = acc_in + BIT;

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_s[k] <= rem_in - trial;
				acc_s[k] <= (acc_in >> 1) + BIT;
			end else begin
				rem_s[k] <= rem_in;
				acc_s[k] <= acc_in >> 1;
			end
		end
	end

	assign root = acc_s[SQRT_LAT-1][NW-1:0];
endmodule

@@ design/vamr_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module vamr_div (
	input  logic                    clk,
	input  logic [2*vamr_pkg::WB:0] num,
	input  logic [vamr_pkg::WB:0]   den,
	output logic [vamr_pkg::WB:0]   quo
);
	import vamr_pkg::*;

	logic [WB:0] rem_s [DIV_LAT];
	logic [WB:0] lo_s  [DIV_LAT];
	logic [WB:0] den_s [DIV_LAT];
	logic [WB:0] quo_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
		logic [WB:0]   rem_in;
		logic [WB:0]   lo_in;
		logic [WB:0]   den_in;
		logic [WB:0]   quo_in;
		logic [WB+1:0] t;
		logic [WB+1:0] diff;

		if (k == 0) begin : g_first
			assign rem_in = (WB+1)'(num[2*WB:WB+1]);
			assign lo_in  = num[WB:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign t    = {rem_in, lo_in[WB-k]};
		assign diff = t - {1'b0, den_in};

		always_ff @(posedge clk) begin
			lo_s[k]  <= lo_in;
			den_s[k] <= den_in;
			if (t >= {1'b0, den_in}) begin
				rem_s[k] <= diff[WB:0];
				quo_s[k] <= {quo_in[WB-1:0], 1'b1};
			end else begin
				rem_s[k] <= t[WB:0];
				quo_s[k] <= {quo_in[WB-1:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];
endmodule

@@ design/vamr_norm.sv @@
// pipelined 3-vector normalizer: block shift, length by square root, per-lane divide
`timescale 1ns / 1ps
module vamr_norm (
	input  logic              clk,
	input  vamr_pkg::vec3_t   vin,
	output vamr_pkg::vec3_t   vout,
	output logic              ok
);
	import vamr_pkg::*;

	localparam int SIDE_W = 3 * WB + 4;

	logic [2:0][NW-1:0]   mag_s1, mag_s2;
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4;
	logic [NW-1:0]        mx_c, mx_s2;
	logic [PW-1:0]        p_c;
	logic [NW-1:0]        shr_c [3];
	logic [NW-1:0]        shl_c [3];
	logic [2:0][WB-1:0]   m_c, m_s3, m_s4;
	logic                 nz_s3, nz_s4;
	logic [2:0][2*WB-1:0] sq_s4;
	logic [DW-1:0]        n2_s5;
	logic [SIDE_W-1:0]    side_s5, side_d;
	logic [NW-1:0]        len;
	logic [2:0][WB-1:0]   m_d;
	logic [2:0]           neg_d;
	logic                 nz_d;
	logic [2:0][WB:0]     quo;
	logic [3:0]           sg_d;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vin[i][NW-1];
			mag_s1[i] <= vin[i][NW-1] ? (~vin[i] + 1'b1) : vin[i];
		end
	end

	always_comb begin
		mx_c = mag_s1[0];
		if (mag_s1[1] > mx_c) begin
			mx_c = mag_s1[1];
		end
		if (mag_s1[2] > mx_c) begin
			mx_c = mag_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		mx_s2  <= mx_c;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// common shift so the largest magnitude has its top bit just below WB
	always_comb begin
		p_c = msb_pos(mx_s2);
		for (int i = 0; i < 3; i++) begin
			shr_c[i] = mag_s2[i] >> (p_c - PW'(WB - 1));
			shl_c[i] = mag_s2[i] << (PW'(WB - 1) - p_c);
			m_c[i]   = (p_c >= PW'(WB - 1)) ? shr_c[i][WB-1:0] : shl_c[i][WB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		m_s3   <= m_c;
		neg_s3 <= neg_s2;
		nz_s3  <= (mx_s2 != '0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= m_s3[i] * m_s3[i];
		end
		m_s4   <= m_s3;
		neg_s4 <= neg_s3;
		nz_s4  <= nz_s3;
	end

	always_ff @(posedge clk) begin
		n2_s5   <= DW'(sq_s4[0]) + DW'(sq_s4[1]) + DW'(sq_s4[2]);
		side_s5 <= {nz_s4, neg_s4, m_s4};
	end

	vamr_isqrt u_len (
		.clk  (clk),
		.rad  (n2_s5),
		.root (len)
	);

	vamr_delay #(.W(SIDE_W), .D(SQRT_LAT)) u_side_dly (
		.clk (clk),
		.d   (side_s5),
		.q   (side_d)
	);

	assign {nz_d, neg_d, m_d} = side_d;

	// u = (m * 2^WB + len/2) / len per lane
	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [2*WB:0] num;
		assign num = (2*WB+1)'({m_d[i], {WB{1'b0}}}) + (2*WB+1)'(len[WB:1]);

		vamr_div u_div (
			.clk (clk),
			.num (num),
			.den (len[WB:0]),
			.quo (quo[i])
		);
	end

	vamr_delay #(.W(4), .D(DIV_LAT)) u_sign_dly (
		.clk (clk),
		.d   ({nz_d, neg_d}),
		.q   (sg_d)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vout[i] <= sg_d[i] ? (~NW'(quo[i]) + 1'b1) : NW'(quo[i]);
		end
		ok <= sg_d[3];
	end
endmodule

@@ design/vector_align_rotation_matrix_core.sv @@
// top level: rotation matrix that turns vector a onto vector b, fully pipelined
`timescale 1ns / 1ps
// usage
//   input channel: drive args (a_x..b_z, signed) and pulse start; the transfer
//   happens on any rising edge with start high and busy low. busy is always
//   low, so a new pair can be sent on every clock.
//   output channel: done is high for exactly one cycle while result holds
//   m00..m22 (transpose of the Rodrigues matrix, signed Q1.14, saturated to
//   +/-1.0) and the degenerate flag. the result transfer happens at the edge
//   that ends that cycle; the receiver has no way to hold it off, so it must
//   capture every done cycle.
//   the path from the input transfer to the matching done edge runs through
//   the two normalizers in series (each a 32-stage square root followed by a
//   31-stage divider) plus the cross/dot, K-squared and matrix-sum stages.
//   throughput: one pair per cycle.
//   zero vectors and parallel/antiparallel pairs give the identity matrix
//   with degenerate set.
//   reset clears only the valid line; data registers are not reset, and no
//   done pulse appears for pairs in flight at reset.
module vector_align_rotation_matrix_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  vamr_pkg::in_t  args,
	output logic           done,
	output vamr_pkg::out_t result
);
	import vamr_pkg::*;

	localparam logic signed [DW-1:0]    ONE60   = 64'sd1 <<< (2 * WB);
	localparam logic signed [DW-1:0]    ONE64   = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [NW+1:0]    CMAX    = (NW+2)'(64'sd1 <<< WB);
	localparam logic [NW-1:0]           SMAX    = NW'(64'd1 << WB);
	localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(64'sd1 <<< FRAC_BITS);
	localparam int                      QW      = 3 * NW + (WB + 1) + (NW + 1) + 1;

	// round Q.60 sum to the output format and saturate to +/-1.0
	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [DW-1:0] x);
		logic signed [DW-1:0] r;
		r = rnd_shr(x, R_SHIFT);
		if (r > ONE64) begin
			r = ONE64;
		end
		if (r < -ONE64) begin
			r = -ONE64;
		end
		return r[OUT_W-1:0];
	endfunction

	assign busy = 1'b0;

	// valid line, one bit per pipeline stage
	logic [TOTAL_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[TOTAL_LAT-1];

	// normalize both inputs
	vec3_t ah, bh;
	logic  oka, okb;

	vamr_norm u_norm_a (
		.clk  (clk),
		.vin  ({NW'(args.a_z), NW'(args.a_y), NW'(args.a_x)}),
		.vout (ah),
		.ok   (oka)
	);

	vamr_norm u_norm_b (
		.clk  (clk),
		.vin  ({NW'(args.b_z), NW'(args.b_y), NW'(args.b_x)}),
		.vout (bh),
		.ok   (okb)
	);

	// cross and dot products
	logic signed [DW-1:0] xp_s1 [6];
	logic signed [DW-1:0] dp_s1 [3];
	logic signed [DW-1:0] xs_s2 [3];
	logic signed [DW-1:0] ds_s2;
	logic signed [DW-1:0] vr_c  [3];
	logic signed [DW-1:0] cr_c;
	vec3_t                v_s3;
	logic signed [NW+1:0] c_s3;

	always_ff @(posedge clk) begin
		xp_s1[0] <= $signed(ah[1]) * $signed(bh[2]);
		xp_s1[1] <= $signed(ah[2]) * $signed(bh[1]);
		xp_s1[2] <= $signed(ah[2]) * $signed(bh[0]);
		xp_s1[3] <= $signed(ah[0]) * $signed(bh[2]);
		xp_s1[4] <= $signed(ah[0]) * $signed(bh[1]);
		xp_s1[5] <= $signed(ah[1]) * $signed(bh[0]);
		for (int i = 0; i < 3; i++) begin
			dp_s1[i] <= $signed(ah[i]) * $signed(bh[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			xs_s2[i] <= xp_s1[2*i] - xp_s1[2*i+1];
		end
		ds_s2 <= dp_s1[0] + dp_s1[1] + dp_s1[2];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vr_c[i] = rnd_shr(xs_s2[i], WB);
		end
		cr_c = rnd_shr(ds_s2, WB);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v_s3[i] <= vr_c[i][NW-1:0];
		end
		c_s3 <= cr_c[NW+1:0];
	end

	// clamp cosine, form 1 - c
	logic signed [NW+1:0] cc_c;
	logic signed [NW+1:0] omc_c;
	logic signed [NW:0]   omc_s4;

	always_comb begin
		if (c_s3 > CMAX) begin
			cc_c = CMAX;
		end else if (c_s3 < -CMAX) begin
			cc_c = -CMAX;
		end else begin
			cc_c = c_s3;
		end
		omc_c = CMAX - cc_c;
	end

	always_ff @(posedge clk) begin
		omc_s4 <= omc_c[NW:0];
	end

	// sine as the length of the rounded cross product
	logic signed [DW-1:0] vsq_s4 [3];
	logic [DW-1:0]        vv_s5;
	logic [NW-1:0]        vroot;
	logic [WB:0]          s_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vsq_s4[i] <= $signed(v_s3[i]) * $signed(v_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		vv_s5 <= vsq_s4[0] + vsq_s4[1] + vsq_s4[2];
	end

	vamr_isqrt u_sin (
		.clk  (clk),
		.rad  (vv_s5),
		.root (vroot)
	);

	always_ff @(posedge clk) begin
		s_s6 <= (vroot > SMAX) ? SMAX[WB:0] : vroot[WB:0];
	end

	// unit axis
	vec3_t kv;
	logic  okv;

	vamr_norm u_norm_k (
		.clk  (clk),
		.vin  (v_s3),
		.vout (kv),
		.ok   (okv)
	);

	// align side values with the axis
	logic [WB:0]        s_d;
	logic signed [NW:0] omc_d;
	logic               okab_d;
	logic               deg_c;

	vamr_delay #(.W(WB + 1), .D(S_DLY)) u_s_dly (
		.clk (clk),
		.d   (s_s6),
		.q   (s_d)
	);

	vamr_delay #(.W(NW + 1), .D(OMC_DLY)) u_omc_dly (
		.clk (clk),
		.d   (omc_s4),
		.q   (omc_d)
	);

	vamr_delay #(.W(1), .D(AB_DLY)) u_ok_dly (
		.clk (clk),
		.d   (oka & okb),
		.q   (okab_d)
	);

	assign deg_c = ~(okab_d & okv);

	// K squared: k k^T minus |k|^2 on the diagonal, exact before rounding
	logic signed [DW-1:0] kk_s1  [6];
	logic signed [DW-1:0] k2s_s2 [6];
	logic signed [DW-1:0] k2r_c  [6];
	logic signed [NW-1:0] k2_s3  [6];

	always_ff @(posedge clk) begin
		kk_s1[0] <= $signed(kv[0]) * $signed(kv[0]);
		kk_s1[1] <= $signed(kv[1]) * $signed(kv[1]);
		kk_s1[2] <= $signed(kv[2]) * $signed(kv[2]);
		kk_s1[3] <= $signed(kv[0]) * $signed(kv[1]);
		kk_s1[4] <= $signed(kv[0]) * $signed(kv[2]);
		kk_s1[5] <= $signed(kv[1]) * $signed(kv[2]);
	end

	// order: 00, 11, 22, 01, 02, 12
	always_ff @(posedge clk) begin
		k2s_s2[0] <= -(kk_s1[1] + kk_s1[2]);
		k2s_s2[1] <= -(kk_s1[0] + kk_s1[2]);
		k2s_s2[2] <= -(kk_s1[0] + kk_s1[1]);
		k2s_s2[3] <= kk_s1[3];
		k2s_s2[4] <= kk_s1[4];
		k2s_s2[5] <= kk_s1[5];
	end

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			k2r_c[j] = rnd_shr(k2s_s2[j], WB);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			k2_s3[j] <= k2r_c[j][NW-1:0];
		end
	end

	// carry axis, sine, 1 - c and the flag past the K-squared stages
	logic [QW-1:0]      qd;
	vec3_t              k_q;
	logic [WB:0]        s_q;
	logic signed [NW:0] omc_q;
	logic               deg_q;

	vamr_delay #(.W(QW), .D(Q_DLY)) u_q_dly (
		.clk (clk),
		.d   ({kv, s_d, omc_d, deg_c}),
		.q   (qd)
	);

	assign {k_q, s_q, omc_q, deg_q} = qd;

	// matrix terms
	logic signed [DW-1:0] sk_s1 [3];
	logic signed [DW-1:0] om_s1 [6];
	logic                 deg_s1, deg_s2;
	logic signed [DW-1:0] rs_s2 [9];
	out_t                 res_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sk_s1[i] <= $signed({1'b0, s_q}) * $signed(k_q[i]);
		end
		for (int j = 0; j < 6; j++) begin
			om_s1[j] <= omc_q * k2_s3[j];
		end
		deg_s1 <= deg_q;
	end

	// transposed entries, row-major m00..m22
	always_ff @(posedge clk) begin
		rs_s2[0] <= om_s1[0] + ONE60;
		rs_s2[1] <= om_s1[3] + sk_s1[2];
		rs_s2[2] <= om_s1[4] - sk_s1[1];
		rs_s2[3] <= om_s1[3] - sk_s1[2];
		rs_s2[4] <= om_s1[1] + ONE60;
		rs_s2[5] <= om_s1[5] + sk_s1[0];
		rs_s2[6] <= om_s1[4] + sk_s1[1];
		rs_s2[7] <= om_s1[5] - sk_s1[0];
		rs_s2[8] <= om_s1[2] + ONE60;
		deg_s2   <= deg_s1;
	end

	// output register; identity for degenerate pairs
	always_ff @(posedge clk) begin
		if (deg_s2) begin
			res_q.m00 <= ONE_OUT;
			res_q.m01 <= '0;
			res_q.m02 <= '0;
			res_q.m10 <= '0;
			res_q.m11 <= ONE_OUT;
			res_q.m12 <= '0;
			res_q.m20 <= '0;
			res_q.m21 <= '0;
			res_q.m22 <= ONE_OUT;
		end else begin
			res_q.m00 <= to_out(rs_s2[0]);
			res_q.m01 <= to_out(rs_s2[1]);
			res_q.m02 <= to_out(rs_s2[2]);
			res_q.m10 <= to_out(rs_s2[3]);
			res_q.m11 <= to_out(rs_s2[4]);
			res_q.m12 <= to_out(rs_s2[5]);
			res_q.m20 <= to_out(rs_s2[6]);
			res_q.m21 <= to_out(rs_s2[7]);
			res_q.m22 <= to_out(rs_s2[8]);
		end
		res_q.degenerate <= deg_s2;
	end

	assign result = res_q;

	// degenerate transfers carry the identity diagonal and zero m01, m12 and m20
	a_deg_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.m00 == ONE_OUT && result.m11 == ONE_OUT &&
			result.m22 == ONE_OUT && result.m01 == '0 && result.m12 == '0 &&
			result.m20 == '0)
		else $error("degenerate result is not identity");

	// a zero first vector always ends as degenerate
	a_zero_a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(args.a_x == '0 && args.a_y == '0 && args.a_z == '0, TOTAL_LAT)
			|-> result.degenerate)
		else $error("zero input vector not flagged degenerate");

	// diagonal stays within +/-1.0
	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.m00 <= ONE_OUT && result.m00 >= -ONE_OUT &&
			result.m11 <= ONE_OUT && result.m11 >= -ONE_OUT &&
			result.m22 <= ONE_OUT && result.m22 >= -ONE_OUT)
		else $error("diagonal entry outside saturation range");
endmodule
